[sv/rcpwd_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the rc pulse width decoder
// no dependencies

package rcpwd_pkg;

	// measurement phase
	typedef enum logic [1:0] {
		PH_WAIT_LOW  = 2'd0,
		PH_WAIT_HIGH = 2'd1,
		PH_MEASURE   = 2'd2
	} phase_t;

	// configuration register indexes
	localparam logic CFG_CYCLES_PER_US = 1'b0;
	localparam logic CFG_TIMEOUT_MS    = 1'b1;

	// reset values of the configuration registers
	localparam logic [7:0] CYCLES_PER_US_RST = 8'd72;
	localparam logic [7:0] TIMEOUT_MS_RST    = 8'd30;

	// regulation limits and snap values in microseconds
	localparam logic [15:0] US_LOW_LIMIT   = 16'd1100;
	localparam logic [15:0] US_HIGH_LIMIT  = 16'd1900;
	localparam logic [15:0] US_MID_LOW     = 16'd1400;
	localparam logic [15:0] US_MID_HIGH    = 16'd1600;
	localparam logic [10:0] US_MIN_OUT     = 11'd1000;
	localparam logic [10:0] US_MAX_OUT     = 11'd2000;
	localparam logic [10:0] US_CENTER      = 11'd1500;

	// elapsed millisecond counter saturation
	localparam logic [7:0] ELAPSED_MAX = 8'd255;

endpackage

[sv/rc_pulse_width_decoder_unit.sv]
`timescale 1ns / 1ps
// rc pwm pulse width decoder: input register, measurement state and result register
// depends on rcpwd_pkg

// Measures the high time of an RC servo PWM pulse. Each input transaction carries one
// pin sample and a millisecond tick; the block takes one transaction per clock cycle
// and the sample ending a measurement passes the input and result registers. The only
// stall is when a result is waiting in the output register and the next sample would
// reach the decode stage: then s_tready drops until the result is taken. The block
// waits for any pulse in progress to end, then for a rising edge, then counts cycles
// while the pin is high and turns them into microseconds with a prescaler of
// cycles_per_us (zero acts as one). A falling edge gives the width regulated to
// 1000 (below 1100), 2000 (above 1900), 1500 (1401 to 1599) or the width itself;
// more than timeout_ms ticks in one measurement gives 1500 with the timeout flag.
// The width counter saturates at 2^WIDTH_BITS - 1.

module rc_pulse_width_decoder_unit
	import rcpwd_pkg::*;
#(
	parameter int WIDTH_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pin_level, [1] ms_tick, [7:2] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [10:0] pulse_us, [15:11] zero
	output logic        m_tuser    // [0] timed_out
);

	localparam logic [WIDTH_BITS-1:0] US_MAX = {WIDTH_BITS{1'b1}};

	// configuration registers
	logic [7:0] cycles_per_us_q;
	logic [7:0] timeout_ms_q;

	// input stage
	logic valid_s1;
	logic pin_s1;
	logic tick_s1;

	// measurement state
	phase_t                phase_q;
	logic [7:0]            elapsed_q;
	logic [7:0]            prescale_q;
	logic [WIDTH_BITS-1:0] high_q;

	// result register
	logic        out_valid_q;
	logic [10:0] out_us_q;
	logic        out_flag_q;

	// next state and decode
	phase_t                phase_d;
	logic [7:0]            elapsed_d;
	logic [7:0]            prescale_d;
	logic [WIDTH_BITS-1:0] high_d;
	logic [7:0]            elapsed_n;
	logic                  late;
	logic [7:0]            div;
	logic [7:0]            pc_base;
	logic [WIDTH_BITS-1:0] hu_base;
	logic [7:0]            pc_inc;
	logic [7:0]            pc_cnt;
	logic [WIDTH_BITS-1:0] hu_cnt;
	logic [15:0]           hu_ext;
	logic [10:0]           reg_us;
	logic                  emit;
	logic [10:0]           emit_us;
	logic                  emit_flag;
	logic                  advance;
	logic                  proc;

	// pipeline moves unless a result waits and the decode stage holds a sample
	assign advance  = !valid_s1 || !out_valid_q || m_tready;
	assign proc     = advance && valid_s1;
	assign s_tready = advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_per_us_q <= CYCLES_PER_US_RST;
			timeout_ms_q    <= TIMEOUT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CYCLES_PER_US: cycles_per_us_q <= cfg_data;
				CFG_TIMEOUT_MS:    timeout_ms_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pin_s1  <= s_tdata[0];
			tick_s1 <= s_tdata[1];
		end
	end

	// tick counting and timeout check
	assign elapsed_n = (tick_s1 && elapsed_q < ELAPSED_MAX) ? elapsed_q + 8'd1 : elapsed_q;
	assign late      = elapsed_n > timeout_ms_q;
	assign div       = (cycles_per_us_q == 8'd0) ? 8'd1 : cycles_per_us_q;

	// prescaler and width counter; a new pulse starts from zero
	assign pc_base = (phase_q == PH_MEASURE) ? prescale_q : 8'd0;
	assign hu_base = (phase_q == PH_MEASURE) ? high_q : '0;
	assign pc_inc  = pc_base + 8'd1;
	always_comb begin
		if (pc_inc >= div) begin
			pc_cnt = 8'd0;
			hu_cnt = (hu_base == US_MAX) ? hu_base : hu_base + 1'b1;
		end else begin
			pc_cnt = pc_inc;
			hu_cnt = hu_base;
		end
	end

	// width regulation
	assign hu_ext = 16'(high_q);
	always_comb begin
		if (hu_ext < US_LOW_LIMIT) begin
			reg_us = US_MIN_OUT;
		end else if (hu_ext > US_HIGH_LIMIT) begin
			reg_us = US_MAX_OUT;
		end else if (hu_ext > US_MID_LOW && hu_ext < US_MID_HIGH) begin
			reg_us = US_CENTER;
		end else begin
			reg_us = hu_ext[10:0];
		end
	end

	// phase state register and measurement counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_LOW;
			elapsed_q  <= 8'd0;
			prescale_q <= 8'd0;
			high_q     <= '0;
		end else if (proc) begin
			phase_q    <= phase_d;
			elapsed_q  <= elapsed_d;
			prescale_q <= prescale_d;
			high_q     <= high_d;
		end
	end

	// next phase and result selection
	always_comb begin
		phase_d    = phase_q;
		elapsed_d  = elapsed_n;
		prescale_d = prescale_q;
		high_d     = high_q;
		emit       = 1'b0;
		emit_us    = US_CENTER;
		emit_flag  = 1'b0;
		case (phase_q)
			PH_WAIT_HIGH: begin
				if (pin_s1) begin
					phase_d    = PH_MEASURE;
					prescale_d = pc_cnt;
					high_d     = hu_cnt;
				end else if (late) begin
					emit      = 1'b1;
					emit_flag = 1'b1;
				end
			end
			PH_MEASURE: begin
				if (!pin_s1) begin
					emit    = 1'b1;
					emit_us = reg_us;
				end else if (late) begin
					emit      = 1'b1;
					emit_flag = 1'b1;
				end else begin
					prescale_d = pc_cnt;
					high_d     = hu_cnt;
				end
			end
			default: begin
				// wait for low, unused code too
				phase_d = PH_WAIT_LOW;
				if (!pin_s1) begin
					phase_d = PH_WAIT_HIGH;
				end else if (late) begin
					emit      = 1'b1;
					emit_flag = 1'b1;
				end
			end
		endcase
		// every result restarts the measurement
		if (emit) begin
			phase_d    = PH_WAIT_LOW;
			elapsed_d  = 8'd0;
			prescale_d = 8'd0;
			high_d     = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_us_q   <= emit_us;
			out_flag_q <= emit_flag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_us_q};
	assign m_tuser  = out_flag_q;

	// timeout results always carry the center value
	a_timeout_center: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[10:0] == US_CENTER))
		else $error("timeout result is not the center value");

	// measured results stay inside the regulated range
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:0] >= US_MIN_OUT && m_tdata[10:0] <= US_MAX_OUT))
		else $error("result outside regulated range");

	// a waiting result blocks new samples when the decode stage is full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("sample accepted while result would be overwritten");

	// a result restarts the measurement
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit) |=> (phase_q == PH_WAIT_LOW && elapsed_q == 8'd0))
		else $error("measurement not restarted after result");

endmodule

[tb/rc_pulse_width_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for rc_pulse_width_decoder_unit: drives pin samples and ticks,
// predicts every pulse result in place and compares it with the result stream
// depends on rcpwd_pkg and the decoder rtl

module rc_pulse_width_decoder_unit_tb;
	import rcpwd_pkg::*;

	localparam int WIDTH_BITS     = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [10:0] pulse_us;
		logic        timed_out;
	} pulse_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] pin_level, [1] ms_tick, [7:2] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [10:0] pulse_us, [15:11] zero
	logic        m_tuser;   // [0] timed_out

	// idling controls for the sender and the receiver
	int unsigned send_idle_pct   = 0;
	int unsigned recv_stall_pct  = 0;
	int unsigned hold_off_cycles = 0;

	// expected results and run bookkeeping
	pulse_result_t expected_pulses[$];
	pulse_result_t oldest_pulse;
	int unsigned   samples_sent   = 0;
	int unsigned   pulses_seen    = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   quiet_cycles   = 0;

	// predictor copy of configuration and measurement state
	logic [7:0]            us_divider;
	logic [7:0]            ms_limit;
	phase_t                meas_phase;
	logic [7:0]            ms_count;
	logic [7:0]            div_count;
	logic [WIDTH_BITS-1:0] width_count;

	rc_pulse_width_decoder_unit #(
		.WIDTH_BITS(WIDTH_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// prescaler step: one more high cycle, whole microseconds saturate
	function automatic void tick_width_counter();
		logic [7:0] divisor;
		divisor = (us_divider == 8'd0) ? 8'd1 : us_divider;
		div_count = div_count + 8'd1;
		if (div_count >= divisor) begin
			div_count = 8'd0;
			if (width_count != '1)
				width_count = width_count + 1'b1;
		end
	endfunction

	// queue one result and start a new measurement
	function automatic void finish_measurement(input logic [10:0] us, input logic is_timeout);
		pulse_result_t res;
		res.pulse_us = us;
		res.timed_out = is_timeout;
		expected_pulses.push_back(res);
		meas_phase = PH_WAIT_LOW;
		ms_count = '0;
		div_count = '0;
		width_count = '0;
	endfunction

	// predict the effect of one accepted sample
	function automatic void decode_sample(input logic pin, input logic tick);
		logic        late;
		logic [10:0] snapped;
		if (tick && ms_count != ELAPSED_MAX)
			ms_count = ms_count + 8'd1;
		late = ms_count > ms_limit;
		case (meas_phase)
			PH_WAIT_HIGH: begin
				if (pin) begin
					meas_phase = PH_MEASURE;
					div_count = '0;
					width_count = '0;
					tick_width_counter();
				end else if (late) begin
					finish_measurement(US_CENTER, 1'b1);
				end
			end
			PH_MEASURE: begin
				if (!pin) begin
					// snap to the ends and to the center band
					if (width_count < US_LOW_LIMIT)
						snapped = US_MIN_OUT;
					else if (width_count > US_HIGH_LIMIT)
						snapped = US_MAX_OUT;
					else if (width_count > US_MID_LOW && width_count < US_MID_HIGH)
						snapped = US_CENTER;
					else
						snapped = width_count[10:0];
					finish_measurement(snapped, 1'b0);
				end else begin
					tick_width_counter();
					if (late)
						finish_measurement(US_CENTER, 1'b1);
				end
			end
			default: begin
				meas_phase = PH_WAIT_LOW;
				if (!pin)
					meas_phase = PH_WAIT_HIGH;
				else if (late)
					finish_measurement(US_CENTER, 1'b1);
			end
		endcase
	endfunction

	function automatic logic chance(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// one sample transaction, with an optional idle gap in front
	task automatic send_sample(input logic pin, input logic tick);
		if (send_idle_pct != 0 && chance(send_idle_pct)) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom_range(0, 3));
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, tick, pin};
		do @(posedge clk); while (!s_tready);
		decode_sample(pin, tick);
		samples_sent++;
		@(negedge clk);
	endtask

	// low lead-in, a run of high samples, then the falling sample
	task automatic send_pulse(input int unsigned lead_lows, input int unsigned high_len,
			input int unsigned tick_pct);
		repeat (lead_lows) send_sample(1'b0, chance(tick_pct));
		repeat (high_len) send_sample(1'b1, chance(tick_pct));
		send_sample(1'b0, chance(tick_pct));
	endtask

	// stop sending and let every expected result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_pulses.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// write both registers, only while the block is idle
	task automatic configure(input logic [7:0] divider, input logic [7:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CYCLES_PER_US;
		cfg_data <= divider;
		@(negedge clk);
		cfg_index <= CFG_TIMEOUT_MS;
		cfg_data <= limit;
		@(negedge clk);
		cfg_we <= 1'b0;
		us_divider = divider;
		ms_limit = limit;
	endtask

	// timeouts in every phase, zero limit, zero divider, tick on the falling sample
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(8'd1, 8'd0);
		// first tick times out while waiting for the pin to fall
		send_sample(1'b1, 1'b0);
		send_sample(1'b1, 1'b1);
		// timeout while waiting for a rising edge
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		// timeout in the middle of a pulse
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b1, 1'b1);
		// a falling sample gives a width even when late
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b1);
		wait_drained();
		configure(8'd0, 8'd255);
		send_pulse(1, 3, 0);
		wait_drained();
		configure(8'd255, 8'd1);
		send_pulse(2, 2, 0);
		wait_drained();
	endtask

	// elapsed counter saturation and the reset limit
	task automatic test_timeout_limits();
		configure(CYCLES_PER_US_RST, 8'd255);
		repeat (300) send_sample(1'b1, 1'b1);
		send_pulse(1, 100, 100);
		wait_drained();
		configure(CYCLES_PER_US_RST, 8'd254);
		repeat (255) send_sample(1'b1, 1'b1);
		wait_drained();
		configure(CYCLES_PER_US_RST, TIMEOUT_MS_RST);
		repeat (31) send_sample(1'b0, 1'b1);
		wait_drained();
	endtask

	// widths around every regulation boundary and the counter ceiling
	task automatic test_width_regulation();
		int unsigned widths[15] = '{1099, 1100, 1101, 1400, 1401, 1599, 1600, 1601,
			1900, 1901, 2047, 2048, 4095, 4096, 4300};
		configure(8'd1, 8'd255);
		foreach (widths[i])
			send_pulse(1, widths[i], 0);
		wait_drained();
		// floor division with larger dividers
		configure(8'd3, 8'd255);
		send_pulse(1, 3 * 1450 + 2, 0);
		wait_drained();
		configure(8'd7, 8'd255);
		send_pulse(1, 7 * 1234 + 6, 0);
		send_pulse(1, 7 * 1650 + 6, 0);
		wait_drained();
	endtask

	// long receiver hold-off fills the block and stalls the sender
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(8'd1, 8'd255);
		hold_off_cycles = 300;
		repeat (30) send_pulse(1, $urandom_range(1, 4), 0);
		wait_drained();
	endtask

	// mostly well-formed pulses with random widths, some noise that breaks them
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [7:0] divider, input logic [7:0] limit, input int unsigned tick_pct);
		int unsigned first_sample;
		int unsigned first_pulse;
		int unsigned pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		configure(divider, limit);
		first_sample = samples_sent;
		first_pulse = pulses_seen;
		while (samples_sent - first_sample < 163 || pulses_seen - first_pulse < 12) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				repeat ($urandom_range(1, 12))
					send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else if (pick < 19 && divider <= 8'd1)
				send_pulse($urandom_range(1, 3), $urandom_range(1050, 2000), tick_pct);
			else
				send_pulse($urandom_range(1, 3), $urandom_range(1, 40), tick_pct);
		end
		wait_drained();
	endtask

	// receiver: random stalls plus a counted hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				hold_off_cycles--;
			end else begin
				m_tready <= !chance(recv_stall_pct);
			end
		end
	end

	// result check against the oldest expectation, and idle cycle count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			pulses_seen++;
			if (expected_pulses.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result transaction: pulse_us=%0d timed_out=%0b",
						m_tdata[10:0], m_tuser);
			end else begin
				oldest_pulse = expected_pulses.pop_front();
				if (m_tdata[10:0] !== oldest_pulse.pulse_us ||
						m_tuser !== oldest_pulse.timed_out) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result %0d: expected pulse_us=%0d timed_out=%0b, got %0d %0b",
							pulses_seen, oldest_pulse.pulse_us, oldest_pulse.timed_out,
							m_tdata[10:0], m_tuser);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// test sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CYCLES_PER_US;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		us_divider = CYCLES_PER_US_RST;
		ms_limit = TIMEOUT_MS_RST;
		meas_phase = PH_WAIT_LOW;
		ms_count = '0;
		div_count = '0;
		width_count = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_timeout_limits();
		test_width_regulation();
		test_backpressure();
		test_random_traffic(0, 0, 8'd1, 8'($urandom_range(40, 255)), 1);
		test_random_traffic(49, 0, 8'd255, 8'd0, 3);
		test_random_traffic(0, 49, 8'($urandom_range(0, 255)), 8'd255, 10);
		test_random_traffic(36, 36, 8'($urandom_range(2, 8)), 8'($urandom_range(1, 20)), 5);

		repeat (DRAIN_CYCLES) @(negedge clk);
		mismatch_count += expected_pulses.size();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[rc_pulse_width_decoder_unit.f]
sv/rcpwd_pkg.sv
sv/rc_pulse_width_decoder_unit.sv
tb/rc_pulse_width_decoder_unit_tb.sv
